### design/rsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, register indexes and controller/datapath bundles for the
// raster shape index block.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // fixed field widths
  localparam int CELL_VALUE_W = 32;
  localparam int NUM_COLS_W   = 13;
  localparam int NUM_ROWS_W   = 16;
  localparam int EDGE_W       = 30;
  localparam int CELL_W       = 28;
  localparam int SHAPE_W      = 32;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_ENABLE = 2'd2;

  // per-cell edge increment, at most six
  localparam int EDGE_INC_W = 3;

  // ratio unit: q = isqrt(floor(2^28 * E^2 / C))
  localparam int SQ_W       = 2 * EDGE_W;
  localparam int SCALE_SH   = 28;
  localparam int NUM_W      = SQ_W + SCALE_SH;
  localparam int DIV_STEPS  = NUM_W;
  localparam int QUOT_W     = 64;
  localparam int ROOT_W     = QUOT_W / 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;        // latch cell, read line buffer
    logic calc;        // count edges, write line buffer
    logic square;      // square edge total, clear ratio unit
    logic div_step;    // one restoring divide step
    logic root_step;   // one square root digit
    logic result_load; // fill output register
  } rsi_cmd_t;

  typedef struct packed {
    logic win_last;  // current cell is the last of the window
    logic cell_zero; // finished window had no non-null, unmasked cell
  } rsi_status_t;

endpackage

### design/rsi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_if
// Valid/ready channels for cell words, result words and register writes.
// ----------------------------------------------------------------------------
interface rsi_cell_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [rsi_pkg::CELL_VALUE_W-1:0]  cell_value;
  logic                                     cell_null;
  logic                                     mask_keep;

  modport source (output valid, cell_value, cell_null, mask_keep, input ready);
  modport sink   (input valid, cell_value, cell_null, mask_keep, output ready);
endinterface

interface rsi_result_if;
  logic                           valid;
  logic                           ready;
  logic [rsi_pkg::SHAPE_W-1:0]    lsi_value;
  logic [rsi_pkg::EDGE_W-1:0]     edge_total;
  logic [rsi_pkg::CELL_W-1:0]     cell_total;
  logic                           no_patch;

  modport source (output valid, lsi_value, edge_total, cell_total, no_patch,
                  input ready);
  modport sink   (input valid, lsi_value, edge_total, cell_total, no_patch,
                  output ready);
endinterface

interface rsi_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rsi_pkg::CFG_INDEX_W-1:0]   index;
  logic [rsi_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/rsi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rsi_ram #(
  parameter int  WIDTH = 33,
  parameter int  DEPTH = 4096,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/rsi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_ctrl
// Sequencer: cell intake, window close, divide and root steps, result hand-off.
// ----------------------------------------------------------------------------
module rsi_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  output rsi_pkg::rsi_cmd_t     cmd,
  input  rsi_pkg::rsi_status_t  st
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_SQR,
    S_DIV,
    S_ROOT,
    S_DONE
  } state_t;

  state_t                      state;
  logic [rsi_pkg::STEP_W-1:0]  step;
  logic                        out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd             = '0;
    cmd.load        = (state == S_IDLE) && in_valid;
    cmd.calc        = (state == S_CELL);
    cmd.square      = (state == S_SQR);
    cmd.div_step    = (state == S_DIV);
    cmd.root_step   = (state == S_ROOT);
    cmd.result_load = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CELL;
          end
        end
        S_CELL: begin
          state <= st.win_last ? S_SQR : S_IDLE;
        end
        S_SQR: begin
          if (st.cell_zero) begin
            state <= S_DONE;
          end else begin
            step  <= rsi_pkg::STEP_W'(rsi_pkg::DIV_STEPS - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (step == '0) begin
            step  <= rsi_pkg::STEP_W'(rsi_pkg::ROOT_STEPS - 1);
            state <= S_ROOT;
          end else begin
            step <= step - rsi_pkg::STEP_W'(1);
          end
        end
        S_ROOT: begin
          if (step == '0) begin
            state <= S_DONE;
          end else begin
            step <= step - rsi_pkg::STEP_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/rsi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_dp
// Datapath: config registers, line buffer, edge counting and the ratio unit
// (restoring divide then digit-by-digit square root).
// ----------------------------------------------------------------------------
module rsi_dp #(
  parameter int MAX_COLS    = 4096,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rsi_pkg::rsi_cmd_t                      cmd,
  output rsi_pkg::rsi_status_t                   st,
  input  logic signed [rsi_pkg::CELL_VALUE_W-1:0] cell_value,
  input  logic                                   cell_null,
  input  logic                                   mask_keep,
  input  logic                                   cfg_valid,
  input  logic [rsi_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic [rsi_pkg::SHAPE_W-1:0]            lsi_value,
  output logic [rsi_pkg::EDGE_W-1:0]             edge_total,
  output logic [rsi_pkg::CELL_W-1:0]             cell_total,
  output logic                                   no_patch
);

  localparam int IDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int CMP_W  = ((rsi_pkg::NUM_COLS_W > CNT_W) ? rsi_pkg::NUM_COLS_W : CNT_W) + 1;
  localparam int VW     = VALUE_WIDTH;
  localparam int ENT_W  = VW + 1;
  localparam int RR_W   = rsi_pkg::ROOT_W + 2;
  localparam int RT_W   = RR_W + 2;
  localparam int ROW_W  = rsi_pkg::NUM_ROWS_W;

  // configuration
  logic [rsi_pkg::NUM_COLS_W-1:0] num_cols;
  logic [ROW_W-1:0]               num_rows;
  logic                           mask_enable;

  // window state
  logic [IDX_W-1:0]               col_index;
  logic [ROW_W-1:0]               row_index;
  logic [rsi_pkg::EDGE_W-1:0]     edge_count;
  logic [rsi_pkg::CELL_W-1:0]     cell_count;
  logic [VW-1:0]                  left_val;
  logic                           left_ok;

  // latched cell and finished totals
  logic [VW-1:0]                  cur_val;
  logic                           cur_ok;
  logic [rsi_pkg::EDGE_W-1:0]     fin_edge;
  logic [rsi_pkg::CELL_W-1:0]     fin_cell;

  // ratio unit
  logic [rsi_pkg::NUM_W-1:0]      num_sh;
  logic [rsi_pkg::CELL_W-1:0]     rem;
  logic [rsi_pkg::QUOT_W-1:0]     quot;
  logic [RR_W-1:0]                rrem;
  logic [rsi_pkg::ROOT_W-1:0]     root;

  logic [CNT_W-1:0]               cols_eff;
  logic [ROW_W-1:0]               rows_eff;
  logic [IDX_W-1:0]               col;
  logic                           last_col;
  logic                           last_row;
  logic                           in_ok;
  logic                           cfg_hit;
  logic [ENT_W-1:0]               above;
  logic                           lok;
  logic                           aok;
  logic                           eq_l;
  logic                           eq_a;
  logic [rsi_pkg::EDGE_INC_W-1:0] e_inc;
  logic [rsi_pkg::EDGE_W-1:0]     edge_next;
  logic [rsi_pkg::CELL_W-1:0]     cell_next;
  logic [rsi_pkg::SQ_W-1:0]       edge_sq;
  logic                           div_bit;
  logic [rsi_pkg::CELL_W:0]       div_trial;
  logic                           div_ge;
  logic [rsi_pkg::CELL_W-1:0]     div_rem_next;
  logic [RT_W-1:0]                rt_t;
  logic [RT_W-1:0]                rt_trial;
  logic                           rt_ge;
  logic [RR_W-1:0]                rt_rem_next;

  // effective window size
  always_comb begin
    if (num_cols == '0) begin
      cols_eff = CNT_W'(1);
    end else if (CMP_W'(num_cols) > CMP_W'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(num_cols);
    end
  end

  assign rows_eff = (num_rows == '0) ? ROW_W'(1) : num_rows;
  assign col      = (CNT_W'(col_index) >= cols_eff) ? IDX_W'(cols_eff - CNT_W'(1))
                                                    : col_index;
  assign last_col = (CNT_W'(col) + CNT_W'(1)) >= cols_eff;
  assign last_row = ({1'b0, row_index} + (ROW_W + 1)'(1)) >= {1'b0, rows_eff};

  assign st.win_last  = last_col && last_row;
  assign st.cell_zero = (fin_cell == '0);

  assign in_ok   = !cell_null && !(mask_enable && !mask_keep);
  assign cfg_hit = cfg_valid && ((cfg_index == rsi_pkg::REG_NUM_COLS) ||
                                 (cfg_index == rsi_pkg::REG_NUM_ROWS) ||
                                 (cfg_index == rsi_pkg::REG_MASK_ENABLE));

  // one-row line buffer: non-null bit over value
  rsi_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (cmd.calc),
    .waddr (col),
    .wdata ({cur_ok, (cur_ok ? cur_val : VW'(0))}),
    .re    (cmd.load),
    .raddr (col),
    .rdata (above)
  );

  // edge count for the cell in flight
  assign lok  = (col != '0) && left_ok;
  assign aok  = (row_index != '0) && above[ENT_W-1];
  assign eq_l = (left_val == cur_val);
  assign eq_a = (above[VW-1:0] == cur_val);

  assign e_inc = rsi_pkg::EDGE_INC_W'(cur_ok && (!lok || !eq_l))
               + rsi_pkg::EDGE_INC_W'(cur_ok && (!aok || !eq_a))
               + rsi_pkg::EDGE_INC_W'(cur_ok && last_row)
               + rsi_pkg::EDGE_INC_W'(cur_ok && last_col)
               + rsi_pkg::EDGE_INC_W'(lok && (!cur_ok || !eq_l))
               + rsi_pkg::EDGE_INC_W'(aok && (!cur_ok || !eq_a));

  assign edge_next = edge_count + rsi_pkg::EDGE_W'(e_inc);
  assign cell_next = cell_count + rsi_pkg::CELL_W'(cur_ok);

  // ratio unit step logic
  assign edge_sq      = fin_edge * fin_edge;
  assign div_bit      = num_sh[rsi_pkg::NUM_W-1];
  assign div_trial    = {rem, div_bit};
  assign div_ge       = div_trial >= {1'b0, fin_cell};
  assign div_rem_next = div_ge ? rsi_pkg::CELL_W'(div_trial - {1'b0, fin_cell})
                               : rsi_pkg::CELL_W'(div_trial);

  assign rt_t        = {rrem, quot[rsi_pkg::QUOT_W-1 -: 2]};
  assign rt_trial    = RT_W'({root, 2'b01});
  assign rt_ge       = rt_t >= rt_trial;
  assign rt_rem_next = rt_ge ? RR_W'(rt_t - rt_trial) : RR_W'(rt_t);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols    <= rsi_pkg::NUM_COLS_W'(1);
      num_rows    <= ROW_W'(1);
      mask_enable <= 1'b0;
      col_index   <= '0;
      row_index   <= '0;
      edge_count  <= '0;
      cell_count  <= '0;
      left_val    <= '0;
      left_ok     <= 1'b0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        rsi_pkg::REG_NUM_COLS:    num_cols    <= rsi_pkg::NUM_COLS_W'(cfg_data);
        rsi_pkg::REG_NUM_ROWS:    num_rows    <= ROW_W'(cfg_data);
        rsi_pkg::REG_MASK_ENABLE: mask_enable <= cfg_data[0];
        default: ;
      endcase
      // any register write starts a fresh window
      col_index  <= '0;
      row_index  <= '0;
      edge_count <= '0;
      cell_count <= '0;
      left_val   <= '0;
      left_ok    <= 1'b0;
    end else if (cmd.calc) begin
      if (!last_col) begin
        col_index  <= col + IDX_W'(1);
        left_val   <= cur_ok ? cur_val : VW'(0);
        left_ok    <= cur_ok;
        edge_count <= edge_next;
        cell_count <= cell_next;
      end else begin
        col_index <= '0;
        left_val  <= '0;
        left_ok   <= 1'b0;
        if (!last_row) begin
          row_index  <= row_index + ROW_W'(1);
          edge_count <= edge_next;
          cell_count <= cell_next;
        end else begin
          row_index  <= '0;
          edge_count <= '0;
          cell_count <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_val <= VW'(cell_value);
      cur_ok  <= in_ok;
    end
    if (cmd.calc && last_col && last_row) begin
      fin_edge <= edge_next;
      fin_cell <= cell_next;
    end
    if (cmd.square) begin
      num_sh <= {edge_sq, rsi_pkg::SCALE_SH'(0)};
      rem    <= '0;
      rrem   <= '0;
      root   <= '0;
    end else if (cmd.div_step) begin
      num_sh <= {num_sh[rsi_pkg::NUM_W-2:0], 1'b0};
      rem    <= div_rem_next;
    end else if (cmd.root_step) begin
      rrem <= rt_rem_next;
      root <= {root[rsi_pkg::ROOT_W-2:0], rt_ge};
    end
    if (cmd.div_step) begin
      quot <= {quot[rsi_pkg::QUOT_W-2:0], div_ge};
    end else if (cmd.root_step) begin
      quot <= {quot[rsi_pkg::QUOT_W-3:0], 2'b00};
    end
    if (cmd.result_load) begin
      lsi_value  <= st.cell_zero ? rsi_pkg::SHAPE_W'(0) : root;
      edge_total <= fin_edge;
      cell_total <= fin_cell;
      no_patch   <= st.cell_zero;
    end
  end

endmodule

### design/raster_shape_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_shape_index
// Each cell is accepted in S_IDLE and counted in S_CELL from the line-buffer
// read data. After the window's last cell the ratio unit runs 88 restoring
// divide steps and 32 square root steps before the result word is valid; a
// window with no non-null, unmasked cell (no_patch) skips them.
// Sync reset: 1x1 window, masking off, counts cleared; line buffer not cleared.
// ----------------------------------------------------------------------------
module raster_shape_index #(
  parameter int MAX_COLS    = 4096,
  parameter int VALUE_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  rsi_cell_if.sink        raster,
  rsi_result_if.source    result,
  rsi_cfg_if.sink         cfg
);

  rsi_pkg::rsi_cmd_t     cmd;
  rsi_pkg::rsi_status_t  st;

  // register writes are taken at any time; the user must issue them only while idle (not enforced)
  assign cfg.ready = 1'b1;

  // sequencer: one cell at a time, then the ratio unit, then the output word
  rsi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (raster.valid),
    .in_ready  (raster.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .cmd       (cmd),
    .st        (st)
  );

  // datapath: line buffer, edge/cell counters, divide and root, output register
  rsi_dp #(
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cell_value  (raster.cell_value),
    .cell_null   (raster.cell_null),
    .mask_keep   (raster.mask_keep),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .lsi_value   (result.lsi_value),
    .edge_total  (result.edge_total),
    .cell_total  (result.cell_total),
    .no_patch    (result.no_patch)
  );

endmodule

### design/rsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks for the raster shape index block, bound to the top level.
// ----------------------------------------------------------------------------
module rsi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cell_valid,
  input logic                          cell_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [rsi_pkg::SHAPE_W-1:0]   lsi_value,
  input logic [rsi_pkg::EDGE_W-1:0]    edge_total,
  input logic [rsi_pkg::CELL_W-1:0]    cell_total,
  input logic                          no_patch,
  input logic                          cfg_ready
);

  // result word holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped before it was taken");

  // a cell is always followed by a busy cycle
  a_cell_gap: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_ready |=> !cell_ready)
    else $error("cell accepted in back-to-back cycles");

  // empty window reports zero index and zero cells
  a_no_patch: assert property (@(posedge clk) disable iff (rst)
    res_valid && no_patch |-> (lsi_value == '0) && (cell_total == '0))
    else $error("no_patch word with nonzero index or cell total");

  // a patch has cells and no more edges than its cells have sides
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid && !no_patch |->
      (cell_total != '0) && (edge_total <= {cell_total, 2'b00}))
    else $error("edge total out of range for cell total");

  // register port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("register port not ready");

endmodule

bind raster_shape_index rsi_checker u_rsi_checker (
  .clk         (clk),
  .rst         (rst),
  .cell_valid  (raster.valid),
  .cell_ready  (raster.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .lsi_value   (result.lsi_value),
  .edge_total  (result.edge_total),
  .cell_total  (result.cell_total),
  .no_patch    (result.no_patch),
  .cfg_ready   (cfg.ready)
);
